@@ rtl/sabc_pkg.sv @@
// ----------------------------------------------------------------------------
// sabc_pkg: shared definitions for the sprite blitter
// Types, defaults and register codes used across the blitter files.
// ----------------------------------------------------------------------------
package sabc_pkg;

   localparam int DEF_FRAME_WIDTH  = 64;
   localparam int DEF_FRAME_HEIGHT = 64;
   localparam int DEF_MAX_SPRITE   = 64;

   localparam int CH_W       = 8;
   localparam int COORD_W    = 6;
   localparam int SIZE_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_SIZE = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET  = 7'd16;
   localparam logic [CH_W-1:0]   ALPHA_CLEAR = 8'd0;
   localparam logic [CH_W-1:0]   ALPHA_FULL  = 8'd255;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pix_type;

   typedef struct packed {
      logic               hit;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } pos_type;

endpackage

@@ rtl/sabc_if.sv @@
// ----------------------------------------------------------------------------
// sabc_if: item channels of the sprite blitter
// Valid/ready channels for sprite pixels in and written pixels out.
// ----------------------------------------------------------------------------
interface sabc_req_if import sabc_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] src_red;
   logic [CH_W-1:0] src_green;
   logic [CH_W-1:0] src_blue;
   logic [CH_W-1:0] src_alpha;
   logic            start_sprite;

   modport source (output valid, src_red, src_green, src_blue, src_alpha, start_sprite,
                   input ready);
   modport sink (input valid, src_red, src_green, src_blue, src_alpha, start_sprite,
                 output ready);
endinterface

interface sabc_rsp_if import sabc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] write_x;
   logic [COORD_W-1:0] write_y;
   logic [CH_W-1:0]    out_red;
   logic [CH_W-1:0]    out_green;
   logic [CH_W-1:0]    out_blue;

   modport source (output valid, write_x, write_y, out_red, out_green, out_blue,
                   input ready);
   modport sink (input valid, write_x, write_y, out_red, out_green, out_blue,
                 output ready);
endinterface

@@ rtl/sprite_alpha_blit_clipped.sv @@
// ----------------------------------------------------------------------------
// sprite_alpha_blit_clipped: alpha-blended sprite blitter into a frame store
//
//   channel   dir  handshake         payload
//   req_chan  in   valid/ready       src_red src_green src_blue src_alpha start_sprite
//   rsp_chan  out  valid/ready       write_x write_y out_red out_green out_blue
//   csr_*     in   csr_wr_en only    csr_index csr_wr_data
//
// One item per cycle while req_chan.ready is high; a written pixel passes stage 1, stage 2
// and the result register before it shows on rsp_chan. The frame store does a
// read-modify-write per item, with forwarding of the two writes still in flight;
// the read port and the blend stages set the rate. After reset a clearing pass over all
// FRAME_WIDTH*FRAME_HEIGHT addresses zeroes the store and req_chan.ready stays low; csr writes are taken throughout.
// A stalled result holds the pipeline only while stage 2 and the result register are both full.
// ----------------------------------------------------------------------------
module sprite_alpha_blit_clipped import sabc_pkg::*; #(
   parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
   parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
   parameter int MAX_SPRITE   = DEF_MAX_SPRITE
) (
   input  logic                  clock,
   input  logic                  reset,
   sabc_req_if.sink              req_chan,
   sabc_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   logic          advance;
   logic          mem_ready;
   logic          accept;
   pos_type       pos;
   logic [AW-1:0] addr;
   pix_type       src;
   pix_type       rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   pix_type       wr_data;

   assign req_chan.ready = advance && mem_ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      src.red   = req_chan.src_red;
      src.green = req_chan.src_green;
      src.blue  = req_chan.src_blue;
   end

   sabc_cursor #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .MAX_SPRITE   (MAX_SPRITE),
      .AW           (AW)
   ) u_cursor (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .accept       (accept),
      .start_sprite (req_chan.start_sprite),
      .src_alpha    (req_chan.src_alpha),
      .pos          (pos),
      .addr         (addr)
   );

   sabc_frame_mem #(
      .DEPTH   (DEPTH),
      .AW      (AW)
   ) u_frame_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .ready   (mem_ready)
   );

   sabc_blend_pipe #(
      .AW      (AW)
   ) u_blend_pipe (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .pos     (pos),
      .addr    (addr),
      .src     (src),
      .alpha   (req_chan.src_alpha),
      .rd_data (rd_data),
      .advance (advance),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rsp     (rsp_chan)
   );

endmodule

@@ rtl/sabc_cursor.sv @@
// ----------------------------------------------------------------------------
// sabc_cursor: sprite position, clipping and frame address
// Holds the origin and size registers and the row and column counters.
// ----------------------------------------------------------------------------
module sabc_cursor import sabc_pkg::*; #(
   parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
   parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
   parameter int MAX_SPRITE   = DEF_MAX_SPRITE,
   parameter int AW           = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic                  accept,
   input  logic                  start_sprite,
   input  logic [CH_W-1:0]       src_alpha,
   output pos_type               pos,
   output logic [AW-1:0]         addr
);

   localparam int CNT_W = $clog2(MAX_SPRITE);
   localparam int ZW    = (CNT_W + 1 > SIZE_W) ? CNT_W + 1 : SIZE_W;
   localparam int P0    = (CNT_W + 2 > 10) ? CNT_W + 2 : 10;
   localparam int P1    = ($clog2(FRAME_WIDTH) + 2 > P0) ? $clog2(FRAME_WIDTH) + 2 : P0;
   localparam int PW    = ($clog2(FRAME_HEIGHT) + 2 > P1) ? $clog2(FRAME_HEIGHT) + 2 : P1;

   logic signed [CH_W-1:0] origin_x_ff;
   logic signed [CH_W-1:0] origin_y_ff;
   logic [SIZE_W-1:0]      size_ff;
   logic [CNT_W-1:0]       col_ff, col_in;
   logic [CNT_W-1:0]       row_ff, row_in;
   logic [CNT_W-1:0]       col_cur, row_cur;
   logic [ZW-1:0]          size_ext, size_eff, col_inc, row_inc;
   logic signed [PW-1:0]   px, py;
   logic                   in_x, in_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         size_ff     <= SIZE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ORIGIN_X:    origin_x_ff <= csr_wr_data;
            CSR_ORIGIN_Y:    origin_y_ff <= csr_wr_data;
            CSR_SPRITE_SIZE: size_ff     <= csr_wr_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   assign size_ext = ZW'(size_ff);
   assign size_eff = (size_ext == '0) ? ZW'(1) :
                     (size_ext > ZW'(MAX_SPRITE)) ? ZW'(MAX_SPRITE) : size_ext;

   assign col_cur = start_sprite ? '0 : col_ff;
   assign row_cur = start_sprite ? '0 : row_ff;
   assign col_inc = ZW'(col_cur) + ZW'(1);
   assign row_inc = ZW'(row_cur) + ZW'(1);

   always_comb begin
      col_in = col_inc[CNT_W-1:0];
      row_in = row_cur;
      if (col_inc >= size_eff) begin
         col_in = '0;
         row_in = (row_inc >= size_eff) ? '0 : row_inc[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign px   = PW'(origin_x_ff) + $signed(PW'(col_cur));
   assign py   = PW'(origin_y_ff) + $signed(PW'(row_cur));
   assign in_x = !px[PW-1] && (px < $signed(PW'(FRAME_WIDTH)));
   assign in_y = !py[PW-1] && (py < $signed(PW'(FRAME_HEIGHT)));

   assign pos.hit = in_x && in_y && (src_alpha != ALPHA_CLEAR);
   assign pos.x   = px[COORD_W-1:0];
   assign pos.y   = py[COORD_W-1:0];
   assign addr    = AW'($unsigned(py)) * AW'(FRAME_WIDTH) + AW'($unsigned(px));

endmodule

@@ rtl/sabc_frame_mem.sv @@
// ----------------------------------------------------------------------------
// sabc_frame_mem: frame store
// One read and one write port, registered read, clearing pass after reset.
// ----------------------------------------------------------------------------
module sabc_frame_mem import sabc_pkg::*; #(
   parameter int DEPTH = DEF_FRAME_WIDTH * DEF_FRAME_HEIGHT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output pix_type       rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  pix_type       wr_data,
   output logic          ready
);

   pix_type       frame_mem_ff [DEPTH];
   pix_type       rd_data_ff;
   logic          clearing_ff;
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         frame_mem_ff[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         frame_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= frame_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clearing_ff;

   a_no_write_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clearing_ff |-> !wr_en)
      else $error("pixel write during clearing pass");

   a_clear_done_sticks: assert property (
      @(posedge clock) disable iff (reset) !clearing_ff |=> !clearing_ff)
      else $error("clearing pass restarted without reset");

endmodule

@@ rtl/sabc_blend_pipe.sv @@
// ----------------------------------------------------------------------------
// sabc_blend_pipe: blend pipeline and result register
// Forwards pending writes, blends per channel and writes the frame back.
// ----------------------------------------------------------------------------
module sabc_blend_pipe import sabc_pkg::*; #(
   parameter int AW = $clog2(DEF_FRAME_WIDTH * DEF_FRAME_HEIGHT)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  pos_type         pos,
   input  logic [AW-1:0]   addr,
   input  pix_type         src,
   input  logic [CH_W-1:0] alpha,
   input  pix_type         rd_data,
   output logic            advance,
   output logic            wr_en,
   output logic [AW-1:0]   wr_addr,
   output pix_type         wr_data,
   sabc_rsp_if.source      rsp
);

   localparam int PRD_W = 2 * CH_W;

   // stage 1: read data back, forward, multiply
   logic               s1_valid_ff;
   logic [AW-1:0]      s1_addr_ff;
   pix_type            s1_src_ff;
   logic [CH_W-1:0]    s1_alpha_ff;
   logic [COORD_W-1:0] s1_x_ff, s1_y_ff;

   // stage 2: sum and divide, write back
   logic                  s2_valid_ff;
   logic [AW-1:0]         s2_addr_ff;
   logic [COORD_W-1:0]    s2_x_ff, s2_y_ff;
   logic [2:0][PRD_W-1:0] s2_src_prod_ff, s2_dst_prod_ff;

   // last write, still unseen by a read issued on the same edge
   logic          s3_valid_ff;
   logic [AW-1:0] s3_addr_ff;
   pix_type       s3_data_ff;

   logic               out_valid_ff;
   logic [COORD_W-1:0] out_x_ff, out_y_ff;
   pix_type            out_pix_ff;

   pix_type                dst;
   logic [2:0][CH_W-1:0]   src_ch, dst_ch, res_ch;
   logic [CH_W-1:0]        inv_alpha;
   logic [2:0][PRD_W-1:0]  src_prod, dst_prod;
   logic [2:0][PRD_W-1:0]  sum;
   logic [2:0][PRD_W:0]    quot;
   pix_type                s2_result;

   assign advance = !s2_valid_ff || !out_valid_ff || rsp.ready;
   assign wr_en   = advance && s2_valid_ff;
   assign wr_addr = s2_addr_ff;
   assign wr_data = s2_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && pos.hit;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_addr_ff     <= addr;
         s1_src_ff      <= src;
         s1_alpha_ff    <= alpha;
         s1_x_ff        <= pos.x;
         s1_y_ff        <= pos.y;
         s2_addr_ff     <= s1_addr_ff;
         s2_x_ff        <= s1_x_ff;
         s2_y_ff        <= s1_y_ff;
         s2_src_prod_ff <= src_prod;
         s2_dst_prod_ff <= dst_prod;
         s3_addr_ff     <= s2_addr_ff;
         s3_data_ff     <= s2_result;
      end
   end

   always_comb begin
      if (s2_valid_ff && (s2_addr_ff == s1_addr_ff)) begin
         dst = s2_result;
      end else if (s3_valid_ff && (s3_addr_ff == s1_addr_ff)) begin
         dst = s3_data_ff;
      end else begin
         dst = rd_data;
      end
   end

   assign src_ch    = s1_src_ff;
   assign dst_ch    = dst;
   assign inv_alpha = ALPHA_FULL - s1_alpha_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         src_prod[c] = PRD_W'(src_ch[c]) * PRD_W'(s1_alpha_ff);
         dst_prod[c] = PRD_W'(dst_ch[c]) * PRD_W'(inv_alpha);
      end
   end

   // divide by 255 as (x + 1 + x/256) / 256, exact over the blend range
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum[c]    = s2_src_prod_ff[c] + s2_dst_prod_ff[c];
         quot[c]   = (PRD_W + 1)'(sum[c]) + (PRD_W + 1)'(1) + (PRD_W + 1)'(sum[c] >> CH_W);
         res_ch[c] = quot[c][PRD_W-1:CH_W];
      end
   end

   assign s2_result = res_ch;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (wr_en) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         out_x_ff   <= s2_x_ff;
         out_y_ff   <= s2_y_ff;
         out_pix_ff <= s2_result;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.write_x   = out_x_ff;
   assign rsp.write_y   = out_y_ff;
   assign rsp.out_red   = out_pix_ff.red;
   assign rsp.out_green = out_pix_ff.green;
   assign rsp.out_blue  = out_pix_ff.blue;

   a_write_reaches_output: assert property (
      @(posedge clock) disable iff (reset) wr_en |=> out_valid_ff)
      else $error("written pixel missing from result register");

   a_stalled_stage_holds: assert property (
      @(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_addr_ff)))
      else $error("stage 1 item lost during stall");

endmodule
